[src/engb_pkg.sv]
`default_nettype none

package engb_pkg;

  // Widths of the item and configuration fields.
  localparam int COORD_W = 16;
  localparam int IDX_W   = 6;
  localparam int SQ_W    = 34;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MODE   = 3'd5;

  typedef logic [IDX_W-1:0] idx_t;

  // One input item: a point.
  typedef struct packed {
    logic                      new_cloud;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  // One result item: an edge, a closing item or an overflow item.
  typedef struct packed {
    idx_t lower_index;
    idx_t upper_index;
    logic edge_valid;
    logic overflow;
    logic last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue_cmp;
    logic issue_close;
    logic emit_ovf;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;
    logic at_end;
    logic full;
    logic close_done;
  } status_t;

endpackage

`default_nettype wire

[src/engb_ctrl.sv]
`default_nettype none

module engb_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  engb_pkg::status_t  status_i,
  output engb_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OVF   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new point is taken only while no other point is at work.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.full ? ST_OVF : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.adv) begin
          if (status_i.at_end) begin
            cmd_o.issue_close = 1'b1;
            state_d = ST_DRAIN;
          end else begin
            cmd_o.issue_cmp = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (status_i.close_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (status_i.adv) begin
          cmd_o.emit_ovf = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/engb_datapath.sv]
`default_nettype none

module engb_datapath #(
  parameter int MaxPoints = 64
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  engb_pkg::cmd_t                        cmd_i,
  output engb_pkg::status_t                     status_o,
  input  engb_pkg::in_item_t                    in_data_i,
  input  wire                                   cfg_valid_i,
  input  wire [engb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [engb_pkg::SQ_W-1:0]              cfg_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output engb_pkg::out_item_t                   out_data_o
);

  localparam int IdxW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CntW  = $clog2(MaxPoints + 1);
  localparam int CW    = engb_pkg::COORD_W;
  localparam int SqW   = engb_pkg::SQ_W;
  localparam int EntW  = 3 * CW + 1;
  localparam int ProdW = 2 * CW;

  // Configuration registers.
  logic [SqW-1:0]       thr_q, rad_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic                 local_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      rad_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      local_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        engb_pkg::CFG_THRESHOLD_SQ: thr_q   <= cfg_data_i;
        engb_pkg::CFG_RADIUS_SQ:    rad_q   <= cfg_data_i;
        engb_pkg::CFG_CENTER_X:     cx_q    <= cfg_data_i[CW-1:0];
        engb_pkg::CFG_CENTER_Y:     cy_q    <= cfg_data_i[CW-1:0];
        engb_pkg::CFG_CENTER_Z:     cz_q    <= cfg_data_i[CW-1:0];
        engb_pkg::CFG_LOCAL_MODE:   local_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves only when the output register can take a result.
  logic adv;
  assign adv = !out_valid_o || !out_stall_i;

  // Point under work.
  logic signed [CW-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q <= in_data_i.coord_x;
      py_q <= in_data_i.coord_y;
      pz_q <= in_data_i.coord_z;
    end
  end

  // Point count and scan index.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            s2_vld_q, s2_close_q;
  logic            close_fire;

  assign close_fire = adv && s2_vld_q && s2_close_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.accept && in_data_i.new_cloud) begin
      count_d = '0;
    end else if (close_fire) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    issue_d = issue_q;
    if (cmd_i.accept) begin
      issue_d = '0;
    end else if (cmd_i.issue_cmp) begin
      issue_d = issue_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      issue_q <= '0;
    end else begin
      count_q <= count_d;
      issue_q <= issue_d;
    end
  end

  // Status toward the controller.
  assign status_o.adv        = adv;
  assign status_o.at_end     = (issue_q == count_q);
  assign status_o.full       = !in_data_i.new_cloud && (count_q >= CntW'(MaxPoints));
  assign status_o.close_done = close_fire;

  // Point store: coordinates and inside flag, one entry per point.
  logic [EntW-1:0] mem_q [MaxPoints];
  logic [EntW-1:0] rd_q;
  logic            mem_we;
  logic            in_region;

  assign mem_we = close_fire;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IdxW-1:0]] <= {px_q, py_q, pz_q, in_region};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_cmp) begin
      rd_q <= mem_q[issue_q[IdxW-1:0]];
    end
  end

  // Stage 1 tags: which stored point, or the closing pass against the center.
  logic            s1_vld_q, s1_close_q;
  logic [IdxW-1:0] s1_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= cmd_i.issue_cmp || cmd_i.issue_close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_close_q <= cmd_i.issue_close;
      s1_j_q     <= issue_q[IdxW-1:0];
    end
  end

  // Stage 2: absolute coordinate differences squared.
  logic signed [CW-1:0] ax, ay, az;
  logic                 a_flag;
  logic [CW-1:0]        dx, dy, dz;

  always_comb begin
    if (s1_close_q) begin
      ax     = cx_q;
      ay     = cy_q;
      az     = cz_q;
      a_flag = 1'b0;
    end else begin
      ax     = rd_q[EntW-1 -: CW];
      ay     = rd_q[EntW-1-CW -: CW];
      az     = rd_q[EntW-1-2*CW -: CW];
      a_flag = rd_q[0];
    end
  end

  function automatic logic [CW-1:0] abs_diff(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic        [CW:0] m;
    d = {a[CW-1], a} - {b[CW-1], b};
    m = d[CW] ? (~d + (CW+1)'(1)) : d;
    return m[CW-1:0];
  endfunction

  assign dx = abs_diff(ax, px_q);
  assign dy = abs_diff(ay, py_q);
  assign dz = abs_diff(az, pz_q);

  logic [ProdW-1:0] sqx_q, sqy_q, sqz_q;
  logic             s2_flag_q;
  logic [IdxW-1:0]  s2_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q      <= dx * dx;
      sqy_q      <= dy * dy;
      sqz_q      <= dz * dz;
      s2_flag_q  <= a_flag;
      s2_close_q <= s1_close_q;
      s2_j_q     <= s1_j_q;
    end
  end

  // Stage 3: sum of squares against the threshold or the radius.
  logic [SqW-1:0] dsum;
  logic           below;
  logic           hit;

  assign dsum      = SqW'(sqx_q) + SqW'(sqy_q) + SqW'(sqz_q);
  assign below     = dsum < (s2_close_q ? rad_q : thr_q);
  assign in_region = below;
  assign hit       = s2_vld_q && !s2_close_q && below && (!local_q || s2_flag_q);

  // Output register.
  logic                out_valid_q;
  engb_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= hit || close_fire || cmd_i.emit_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cmd_i.emit_ovf) begin
        out_q.lower_index <= '0;
        out_q.upper_index <= '0;
        out_q.edge_valid  <= 1'b0;
        out_q.overflow    <= 1'b1;
        out_q.last        <= 1'b1;
      end else if (close_fire) begin
        out_q.lower_index <= '0;
        out_q.upper_index <= engb_pkg::idx_t'(count_q);
        out_q.edge_valid  <= 1'b0;
        out_q.overflow    <= 1'b0;
        out_q.last        <= 1'b1;
      end else begin
        out_q.lower_index <= engb_pkg::idx_t'(s2_j_q);
        out_q.upper_index <= engb_pkg::idx_t'(count_q);
        out_q.edge_valid  <= 1'b1;
        out_q.overflow    <= 1'b0;
        out_q.last        <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/epsilon_neighbor_graph_builder_top.sv]
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        input      in_valid / stall   in_item_t: new_cloud, coord_x/y/z
// out       output     out_valid / stall  out_item_t: lower/upper index, flags
// cfg       input      cfg_valid / ready  cfg_index (3 bit), cfg_data (34 bit)
//
// A point is compared with every stored point before its closing item: one
// comparison per cycle while the output does not stall, through the store's
// read port, behind a three-stage distance pipeline. A point that finds the
// store full returns only its overflow item.
// Reset empties the store at once through the point count; no clearing pass.
// A stall on the output holds the whole comparison pipeline in place.

module epsilon_neighbor_graph_builder_top #(
  parameter int MaxPoints = 64
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  engb_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output engb_pkg::out_item_t           out_data_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [engb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [engb_pkg::SQ_W-1:0]      cfg_data_i
);

  engb_pkg::cmd_t    cmd;
  engb_pkg::status_t status;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  engb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  engb_datapath #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[src/engb_checker.sv]
`default_nettype none

module engb_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_stall_o,
  input wire                           out_valid_o,
  input wire                           out_stall_i,
  input engb_pkg::out_item_t           out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An accepted point keeps the input stalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // An overflow item carries no edge and ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      !out_data_o.edge_valid && out_data_o.last &&
      (out_data_o.lower_index == '0) && (out_data_o.upper_index == '0))
    else $error("malformed overflow item");

  // An edge links an earlier point to the new one and never ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_valid |->
      !out_data_o.last && !out_data_o.overflow &&
      (out_data_o.lower_index < out_data_o.upper_index))
    else $error("malformed edge item");

  // Every item that is not an edge ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.edge_valid |-> out_data_o.last)
    else $error("closing item without last");

endmodule

bind epsilon_neighbor_graph_builder_top engb_checker u_engb_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_W = engb_pkg::COORD_W;
  localparam int IDX_W = engb_pkg::IDX_W;
  localparam int SQ_W = engb_pkg::SQ_W;
  localparam int CFG_IDX_W = engb_pkg::CFG_IDX_W;

  localparam int MAX_POINTS = 64;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;

  // Indexes beyond the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam logic [SQ_W-1:0] SQ_MAX = '1;
  localparam logic [SQ_W-1:0] ONE_SQ = 34'd16777216;
  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] ONE = 16'sd4096;

  // Mirror of the point store and registers; predicts the edge items of each point.
  class edge_scoreboard;
    logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
    logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
    logic signed [COORD_W-1:0] pt_z [MAX_POINTS];
    bit inside_region [MAX_POINTS];
    int unsigned count;
    logic [SQ_W-1:0] thr_sq;
    logic [SQ_W-1:0] rad_sq;
    logic signed [COORD_W-1:0] ctr_x, ctr_y, ctr_z;
    logic local_only;
    engb_pkg::out_item_t expected_q [$];
    int errors, n_points, n_edges, n_closes, n_overflows;

    function new();
      count = 0;
      thr_sq = '0;
      rad_sq = '0;
      ctr_x = '0;
      ctr_y = '0;
      ctr_z = '0;
      local_only = 1'b0;
      errors = 0;
      n_points = 0;
      n_edges = 0;
      n_closes = 0;
      n_overflows = 0;
    endfunction

    function longint unsigned dist_sq(int ax, int ay, int az, int bx, int by, int bz);
      longint dx, dy, dz;
      dx = ax - bx;
      dy = ay - by;
      dz = az - bz;
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SQ_W-1:0] val);
      case (idx)
        engb_pkg::CFG_THRESHOLD_SQ: thr_sq = val;
        engb_pkg::CFG_RADIUS_SQ:    rad_sq = val;
        engb_pkg::CFG_CENTER_X:     ctr_x = val[COORD_W-1:0];
        engb_pkg::CFG_CENTER_Y:     ctr_y = val[COORD_W-1:0];
        engb_pkg::CFG_CENTER_Z:     ctr_z = val[COORD_W-1:0];
        engb_pkg::CFG_LOCAL_MODE:   local_only = val[0];
        default: ;
      endcase
    endfunction

    // Appends one predicted item behind the ones already waiting.
    function void queue_item(engb_pkg::out_item_t r);
      expected_q = {expected_q, r};
    endfunction

    // Stores the point and queues its edges, then its closing item; a full store queues only an overflow item.
    function void note_point(engb_pkg::in_item_t p);
      engb_pkg::out_item_t r;
      bit near;
      n_points++;
      if (p.new_cloud) count = 0;
      if (count >= MAX_POINTS) begin
        r = '0;
        r.overflow = 1'b1;
        r.last = 1'b1;
        queue_item(r);
        return;
      end
      for (int unsigned j = 0; j < count; j++) begin
        near = dist_sq(pt_x[j], pt_y[j], pt_z[j],
                       p.coord_x, p.coord_y, p.coord_z) < thr_sq;
        if (near && (!local_only || inside_region[j])) begin
          r = '0;
          r.lower_index = engb_pkg::idx_t'(j);
          r.upper_index = engb_pkg::idx_t'(count);
          r.edge_valid = 1'b1;
          queue_item(r);
        end
      end
      r = '0;
      r.upper_index = engb_pkg::idx_t'(count);
      r.last = 1'b1;
      queue_item(r);
      // The region flag is fixed with the registers as they stand now.
      pt_x[count] = p.coord_x;
      pt_y[count] = p.coord_y;
      pt_z[count] = p.coord_z;
      inside_region[count] =
        dist_sq(p.coord_x, p.coord_y, p.coord_z, ctr_x, ctr_y, ctr_z) < rad_sq;
      count++;
    endfunction

    function void compare_field(string name, logic [IDX_W-1:0] expv,
                                logic [IDX_W-1:0] actv);
      if (actv !== expv) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
      end
    endfunction

    function void check_result(engb_pkg::out_item_t got);
      engb_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("lower_index", want.lower_index, got.lower_index);
      compare_field("upper_index", want.upper_index, got.upper_index);
      compare_field("edge_valid", IDX_W'(want.edge_valid), IDX_W'(got.edge_valid));
      compare_field("overflow", IDX_W'(want.overflow), IDX_W'(got.overflow));
      compare_field("last", IDX_W'(want.last), IDX_W'(got.last));
      if (want.overflow) n_overflows++;
      else if (want.edge_valid) n_edges++;
      else n_closes++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  engb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  engb_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SQ_W-1:0] cfg_data = '0;

  edge_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int n_settings = 0;

  epsilon_neighbor_graph_builder_top #(
    .MaxPoints(MAX_POINTS)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: checks each accepted item, then picks the next stall value.
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_data);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d items still expected", $time, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp16(int v);
    if (v > 32767) return C_MAX;
    if (v < -32768) return C_MIN;
    return COORD_W'(v);
  endfunction

  function automatic logic [SQ_W-1:0] junk_hi(bit junk, logic [COORD_W-1:0] low);
    return {(junk ? 18'($urandom) : 18'd0), low};
  endfunction

  // Offers one point, with random idle cycles before it, until it is accepted.
  task automatic send_point(logic nc, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    engb_pkg::in_item_t p;
    p.new_cloud = nc;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    sb.note_point(p);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SQ_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Stops sending and waits until the block has returned every item.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the whole register set; junk puts random bits above the used ones.
  task automatic configure(logic [SQ_W-1:0] thr, logic [SQ_W-1:0] rad,
                           logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                           logic signed [COORD_W-1:0] cz, logic lm, bit junk);
    write_reg(engb_pkg::CFG_THRESHOLD_SQ, thr);
    write_reg(engb_pkg::CFG_RADIUS_SQ, rad);
    write_reg(engb_pkg::CFG_CENTER_X, junk_hi(junk, cx));
    write_reg(engb_pkg::CFG_CENTER_Y, junk_hi(junk, cy));
    write_reg(engb_pkg::CFG_CENTER_Z, junk_hi(junk, cz));
    write_reg(engb_pkg::CFG_LOCAL_MODE, junk_hi(junk, {15'd0, lm}));
    if (junk) write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                        {2'($urandom), 32'($urandom)});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // One cloud of points clustered around a random base, under fresh registers.
  task automatic run_cloud(int n_points, bit hold, bit noise);
    int spread, bx, by, bz;
    logic [SQ_W-1:0] thr, rad;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic nc;
    wait_for_idle();
    spread = 1 << $urandom_range(3, 12);
    bx = int'($signed(16'($urandom)));
    by = int'($signed(16'($urandom)));
    bz = int'($signed(16'($urandom)));
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = SQ_MAX;
      2: thr = {2'($urandom), 32'($urandom)};
      default: thr = SQ_W'(spread * spread * $urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 4))
      0: rad = '0;
      1: rad = SQ_MAX;
      default: rad = SQ_W'(spread * spread * $urandom_range(1, 4));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cx = 16'($urandom);
      cy = 16'($urandom);
      cz = 16'($urandom);
    end else begin
      cx = COORD_W'(bx);
      cy = COORD_W'(by);
      cz = COORD_W'(bz);
    end
    configure(thr, rad, cx, cy, cz, 1'($urandom), 1'($urandom));
    if (hold) hold_token <= hold_token + 1;
    for (int i = 0; i < n_points; i++) begin
      nc = (i == 0) || (noise && $urandom_range(0, 29) == 0);
      if ($urandom_range(0, 7) == 0) begin
        send_point(nc, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_point(nc,
                   clamp16(bx + int'($urandom_range(0, 2 * spread)) - spread),
                   clamp16(by + int'($urandom_range(0, 2 * spread)) - spread),
                   clamp16(bz + int'($urandom_range(0, 2 * spread)) - spread));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly stalling.
    send_idle_pct = 11;
    recv_idle_pct <= 69;

    // Coordinate extremes with the widest threshold.
    configure(SQ_MAX, SQ_MAX, '0, '0, '0, 1'b0, 1'b0);
    send_point(1'b1, '0, '0, '0);
    send_point(1'b0, C_MAX, C_MAX, C_MAX);
    send_point(1'b0, C_MIN, C_MIN, C_MIN);
    send_point(1'b0, C_MAX, C_MIN, C_MAX);
    wait_for_idle();

    // Distances exactly at and just under threshold and radius, local mode.
    configure(ONE_SQ, ONE_SQ, '0, '0, '0, 1'b1, 1'b0);
    send_point(1'b1, '0, '0, '0);
    send_point(1'b0, ONE, '0, '0);
    send_point(1'b0, ONE - 16'sd1, '0, '0);
    send_point(1'b0, '0, -(ONE - 16'sd1), '0);
    wait_for_idle();

    // Global mode with an empty region; the store carries over.
    configure(ONE_SQ, '0, C_MIN, C_MAX, '0, 1'b0, 1'b0);
    send_point(1'b0, ONE, 16'sd1, '0);
    wait_for_idle();

    // Region flags keep the values from arrival, not the new radius.
    configure(ONE_SQ, SQ_MAX, '0, '0, '0, 1'b1, 1'b0);
    send_point(1'b0, ONE, '0, 16'sd1);
    wait_for_idle();

    // Zero threshold yields closing items only; spare indexes are ignored.
    configure('0, SQ_MAX, C_MAX, C_MIN, C_MIN, 1'b0, 1'b1);
    send_point(1'b0, ONE, '0, 16'sd1);
    send_point(1'b1, -16'sd1, -16'sd1, -16'sd1);

    repeat (2) run_cloud($urandom_range(2, 8), 1'b0, 1'b1);

    // Sender mostly idle, receiver mostly ready; fill the store past capacity.
    send_idle_pct = 69;
    recv_idle_pct <= 11;
    run_cloud(MAX_POINTS + 4, 1'b0, 1'b0);
    run_cloud($urandom_range(2, 8), 1'b0, 1'b1);

    // No idling; one cloud runs into a long receiver hold.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_cloud(12, 1'b1, 1'b0);
    run_cloud($urandom_range(2, 8), 1'b0, 1'b1);

    wait_for_idle();
    repeat (END_CYCLES) @(posedge clk);

    $display("Covered %0d points under %0d register settings, all idle patterns and a long hold.",
             sb.n_points, n_settings);
    $display("Checked %0d edges, %0d closing items and %0d overflow items.",
             sb.n_edges, sb.n_closes, sb.n_overflows);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
